### rtl/sst_pkg.sv
// Shared types, codes and sizes of the speaker slot table.
`default_nettype none
package sst_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PORT_SLOTS  = 8;
  localparam int PSLOT_W     = 3;

  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_OLDEST = 3'd2;
  localparam logic [2:0] KIND_NEWEST = 3'd3;
  localparam logic [2:0] KIND_FREE   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CFG_BASE_PORT     = 1'b0;
  localparam logic CFG_SPEAKER_LIMIT = 1'b1;

  localparam logic [3:0] LIMIT_MAX = 4'd8;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } sst_cmd_t;

  typedef struct packed {
    logic scan_last;
  } sst_sts_t;

endpackage
`default_nettype wire

### rtl/sst_if.sv
// Item channel interfaces: request items in, result items out.
`default_nettype none
interface sst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] client_id;
  logic        is_chairman;
  logic [15:0] audio_port;

  modport source (output valid, kind, client_id, is_chairman, audio_port, input ready);
  modport sink   (input valid, kind, client_id, is_chairman, audio_port, output ready);
endinterface

interface sst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_id;
  logic [15:0] found_port;

  modport source (output valid, status, found_id, found_port, input ready);
  modport sink   (input valid, status, found_id, found_port, output ready);
endinterface
`default_nettype wire

### rtl/sst_datapath.sv
// Table storage, scan registers, stamp counter, config registers and result register.
`default_nettype none
module sst_datapath import sst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sst_cmd_t    cmd,
  output sst_sts_t         sts,
  input  wire logic [2:0]  in_kind,
  input  wire logic [15:0] in_client_id,
  input  wire logic        in_is_chairman,
  input  wire logic [15:0] in_audio_port,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output logic [1:0]       out_status,
  output logic [15:0]      out_found_id,
  output logic [15:0]      out_found_port
);

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [15:0] ent_client_r [TABLE_DEPTH];
  logic        ent_chair_r  [TABLE_DEPTH];
  logic [15:0] ent_port_r   [TABLE_DEPTH];
  logic [31:0] ent_stamp_r  [TABLE_DEPTH];
  logic [31:0] stamp_r, stamp_nxt;

  logic [15:0] base_r;
  logic [3:0]  limit_r;

  logic [2:0]  kind_r;
  logic [15:0] id_r;
  logic        chair_r;
  logic [15:0] port_r;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             best_r, best_nxt;
  logic [31:0]      best_stamp_r, best_stamp_nxt;
  logic [15:0]      best_id_r, best_id_nxt;
  logic [15:0]      best_port_r, best_port_nxt;
  logic [PORT_SLOTS-1:0] used_r, used_nxt;

  logic [1:0]  status_r, status_nxt;
  logic [15:0] fid_r, fid_nxt;
  logic [15:0] fport_r, fport_nxt;
  logic        wr_en;

  logic        cur_valid, cur_search, better;
  logic [15:0] cur_client, cur_port;
  logic [31:0] cur_stamp;
  logic [16:0] off;
  logic        off_ok;
  logic [PSLOT_W-1:0] off_slot;
  logic [3:0]  limit_eff;
  logic        free_hit;
  logic [15:0] free_port;

  assign sts.scan_last = (idx_r == IDX_W'(TABLE_DEPTH - 1));

  assign cur_valid  = valid_r[idx_r];
  assign cur_client = ent_client_r[idx_r];
  assign cur_port   = ent_port_r[idx_r];
  assign cur_stamp  = ent_stamp_r[idx_r];
  assign cur_search = cur_valid && (cur_client != 16'd0) && !ent_chair_r[idx_r];
  assign better     = !best_r || ((kind_r == KIND_NEWEST) ? (cur_stamp > best_stamp_r)
                                                          : (cur_stamp < best_stamp_r));

  // signed port offset; only even offsets 2..16 name a port slot
  assign off      = {1'b0, cur_port} - {1'b0, base_r};
  assign off_ok   = !off[16] && (off[15:0] >= 16'd2) && (off[15:0] <= 16'(2 * PORT_SLOTS))
                    && !off[0];
  assign off_slot = PSLOT_W'(off[4:1] - 4'd1);

  assign limit_eff = (limit_r > LIMIT_MAX) ? LIMIT_MAX : limit_r;

  always_comb begin
    free_hit  = 1'b0;
    free_port = 16'd0;
    for (int i = 0; i < PORT_SLOTS; i++) begin
      if (!free_hit && (4'(i) < limit_eff) && !used_r[i]) begin
        free_hit  = 1'b1;
        free_port = base_r + 16'(2 * (i + 1));
      end
    end
  end

  always_comb begin
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    best_id_nxt    = best_id_r;
    best_port_nxt  = best_port_r;
    used_nxt       = used_r;
    if (cmd.load) begin
      idx_nxt  = '0;
      hit_nxt  = 1'b0;
      best_nxt = 1'b0;
      used_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (!hit_r && (((kind_r == KIND_ADD) && !cur_valid) ||
                     ((kind_r == KIND_REMOVE) && cur_valid && (cur_client == id_r)))) begin
        hit_nxt  = 1'b1;
        slot_nxt = idx_r;
      end
      if (cur_search && better) begin
        best_nxt       = 1'b1;
        best_stamp_nxt = cur_stamp;
        best_id_nxt    = cur_client;
        best_port_nxt  = cur_port;
      end
      if (cur_search && off_ok) used_nxt[off_slot] = 1'b1;
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    stamp_nxt  = stamp_r;
    wr_en      = 1'b0;
    status_nxt = ST_OK;
    fid_nxt    = 16'd0;
    fport_nxt  = 16'd0;
    case (kind_r)
      KIND_ADD: begin
        if (hit_r) begin
          wr_en            = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          stamp_nxt        = (stamp_r == STAMP_MAX) ? stamp_r : stamp_r + 32'd1;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (hit_r) valid_nxt[slot_r] = 1'b0;
        else       status_nxt = ST_NONE;
      end
      KIND_OLDEST, KIND_NEWEST: begin
        if (best_r && ((kind_r == KIND_NEWEST) ? (best_stamp_r != 32'd0)
                                               : (best_stamp_r != STAMP_MAX))) begin
          fid_nxt   = best_id_r;
          fport_nxt = best_port_r;
        end else begin
          status_nxt = ST_NONE;
        end
      end
      KIND_FREE: begin
        if (free_hit) fport_nxt = free_port;
        else          status_nxt = ST_NONE;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      stamp_r <= 32'd0;
      base_r  <= 16'd0;
      limit_r <= LIMIT_MAX;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      best_r  <= 1'b0;
      used_r  <= '0;
    end else begin
      if (cmd.commit) begin
        valid_r <= valid_nxt;
        stamp_r <= stamp_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_PORT:     base_r  <= cfg_wdata;
          CFG_SPEAKER_LIMIT: limit_r <= cfg_wdata[3:0];
          default:           base_r  <= base_r;
        endcase
      end
      idx_r  <= idx_nxt;
      hit_r  <= hit_nxt;
      best_r <= best_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_id_r    <= best_id_nxt;
    best_port_r  <= best_port_nxt;
    if (cmd.load) begin
      kind_r  <= in_kind;
      id_r    <= in_client_id;
      chair_r <= in_is_chairman;
      port_r  <= in_audio_port;
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      fid_r    <= fid_nxt;
      fport_r  <= fport_nxt;
    end
    if (cmd.commit && wr_en) begin
      ent_client_r[slot_r] <= id_r;
      ent_chair_r[slot_r]  <= chair_r;
      ent_port_r[slot_r]   <= port_r;
      ent_stamp_r[slot_r]  <= stamp_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_found_id   = fid_r;
  assign out_found_port = fport_r;

endmodule
`default_nettype wire

### rtl/sst_ctrl.sv
// Controller: accept, table scan, commit and result handshake.
`default_nettype none
module sst_ctrl import sst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sst_cmd_t      cmd,
  input  wire sst_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   room;

  assign room     = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (room) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/speaker_slot_table.sv
// Top level of the speaker slot table.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    kind, client_id, is_chairman, audio_port
//   out_ch   out  valid / ready    status, found_id, found_port
//   cfg_     in   cfg_we           cfg_index, cfg_wdata
//
// Each item goes through accept, a scan of one table slot per cycle through the
// scan counter, then commit.
// The next item is accepted in the cycle after commit.
// Reset (synchronous, rst_n low) empties the table and zeroes the stamp counter.
// A commit waits while the previous result still sits unread in the output register.
`default_nettype none
module speaker_slot_table import sst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sst_in_if.sink           in_ch,
  sst_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  sst_cmd_t cmd;
  sst_sts_t sts;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sst_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_client_id   (in_ch.client_id),
    .in_is_chairman (in_ch.is_chairman),
    .in_audio_port  (in_ch.audio_port),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_status     (out_ch.status),
    .out_found_id   (out_ch.found_id),
    .out_found_port (out_ch.found_port)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while scan in progress");

  a_scan_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.step, cmd.commit}) <= 1)
    else $error("conflicting controller commands");

  a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |->
      (out_ch.found_id == 16'd0) && (out_ch.found_port == 16'd0))
    else $error("failed result carries payload");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_OK) || (out_ch.status == ST_NONE) ||
                     (out_ch.status == ST_FULL))
    else $error("bad status code");

endmodule
`default_nettype wire

### test/slot_table_checker.sv
// Checker for the speaker slot table: tracks table state, predicts and compares each result.
`timescale 1ns / 1ps
module slot_table_checker import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sst_in_if           in_mon,
  sst_out_if          out_mon,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] client_id;
    logic        is_chairman;
    logic [15:0] audio_port;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_id;
    logic [15:0] found_port;
  } reply_t;

  bit          slot_used   [TABLE_DEPTH];
  logic [15:0] slot_client [TABLE_DEPTH];
  bit          slot_chair  [TABLE_DEPTH];
  logic [15:0] slot_port   [TABLE_DEPTH];
  logic [31:0] slot_stamp  [TABLE_DEPTH];
  logic [31:0] age_counter;
  logic [15:0] base_port_q;
  logic [3:0]  limit_q;

  reply_t awaited_replies[$];
  int     errors;
  int     replies_seen;

  function automatic bit is_speaker(int k);
    return slot_used[k] && slot_client[k] != 16'd0 && !slot_chair[k];
  endfunction

  // least stamp for oldest, greatest for newest; ties keep the lowest slot
  function automatic int pick_speaker(bit newest);
    int best;
    best = -1;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (is_speaker(k)) begin
        if (best < 0) begin
          best = k;
        end else if (newest ? slot_stamp[k] > slot_stamp[best]
                            : slot_stamp[k] < slot_stamp[best]) begin
          best = k;
        end
      end
    end
    if (best >= 0) begin
      if (newest && slot_stamp[best] == 32'd0) begin
        best = -1;
      end else if (!newest && slot_stamp[best] == STAMP_MAX) begin
        best = -1;
      end
    end
    return best;
  endfunction

  function automatic reply_t predict_reply(request_t req);
    reply_t r;
    int     slot;
    int     off;
    int     lim;
    bit     taken[PORT_SLOTS];
    r = '0;
    slot = -1;
    case (req.kind)
      KIND_ADD: begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (!slot_used[k] && slot < 0) slot = k;
        end
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          if (age_counter != STAMP_MAX) age_counter++;
          slot_used[slot]   = 1'b1;
          slot_client[slot] = req.client_id;
          slot_chair[slot]  = req.is_chairman;
          slot_port[slot]   = req.audio_port;
          slot_stamp[slot]  = age_counter;
        end
      end
      KIND_REMOVE: begin
        r.status = ST_NONE;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (slot < 0 && slot_used[k] && slot_client[k] == req.client_id) slot = k;
        end
        if (slot >= 0) begin
          slot_used[slot] = 1'b0;
          r.status = ST_OK;
        end
      end
      KIND_OLDEST, KIND_NEWEST: begin
        slot = pick_speaker(req.kind == KIND_NEWEST);
        if (slot < 0) begin
          r.status = ST_NONE;
        end else begin
          r.found_id   = slot_client[slot];
          r.found_port = slot_port[slot];
        end
      end
      KIND_FREE: begin
        foreach (taken[i]) taken[i] = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          if (is_speaker(k)) begin
            off = int'({16'd0, slot_port[k]}) - int'({16'd0, base_port_q});
            if (off >= 2 && off <= 2 * PORT_SLOTS && off % 2 == 0) taken[off / 2 - 1] = 1'b1;
          end
        end
        lim = (limit_q > LIMIT_MAX) ? PORT_SLOTS : int'(limit_q);
        r.status = ST_NONE;
        for (int i = 0; i < lim; i++) begin
          if (!taken[i] && r.status == ST_NONE) begin
            r.found_port = base_port_q + 16'(2 * (i + 1));
            r.status     = ST_OK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    request_t req;
    reply_t   got;
    reply_t   want;
    if (!rst_n) begin
      foreach (slot_used[k]) slot_used[k] = 1'b0;
      age_counter = '0;
      base_port_q = '0;
      limit_q     = LIMIT_MAX;
      awaited_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE_PORT) base_port_q = cfg_wdata;
        else limit_q = cfg_wdata[3:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got.status     = out_mon.status;
        got.found_id   = out_mon.found_id;
        got.found_port = out_mon.found_port;
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d unexpected: status %0d id %h port %h",
                     replies_seen, got.status, got.found_id, got.found_port);
          end
        end else begin
          want = awaited_replies.pop_front();
          if (got.status !== want.status || got.found_id !== want.found_id ||
              got.found_port !== want.found_port) begin
            errors++;
            if (errors <= 10) begin
              $display("result %0d mismatch: status %0d/%0d id %h/%h port %h/%h (exp/act)",
                       replies_seen, want.status, got.status, want.found_id, got.found_id,
                       want.found_port, got.found_port);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.kind        = in_mon.kind;
        req.client_id   = in_mon.client_id;
        req.is_chairman = in_mon.is_chairman;
        req.audio_port  = in_mon.audio_port;
        awaited_replies.push_back(predict_reply(req));
      end
    end
    pending    <= awaited_replies.size();
    fail_count <= errors;
  end

endmodule

### test/speaker_slot_table_test.sv
// Testbench top for the speaker slot table: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module speaker_slot_table_test;
  import sst_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 250;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;
  int fail_count;
  int pending;

  logic [15:0] phase_base  [PHASES] = '{16'd0, 16'd65535, 16'd65530, 16'd1000, 16'd0, 16'd200};
  logic [3:0]  phase_limit [PHASES] = '{4'd8, 4'd15, 4'd3, 4'd0, 4'd0, 4'd9};
  int          phase_send  [PHASES] = '{0, 54, 0, 32, 0, 32};
  int          phase_stall [PHASES] = '{0, 0, 54, 32, 0, 32};

  sst_in_if  in_ch();
  sst_out_if out_ch();

  speaker_slot_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slot_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // no item moved on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(input logic [2:0] kind, input logic [15:0] id,
                              input logic chair, input logic [15:0] port);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.client_id   <= id;
    in_ch.is_chairman <= chair;
    in_ch.audio_port  <= port;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_regs(input logic [15:0] base, input logic [3:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_PORT;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_SPEAKER_LIMIT;
    cfg_wdata <= {12'd0, limit};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          done;
    int          roll;
    logic [2:0]  kind;
    logic [15:0] id;
    logic        chair;
    logic [15:0] port;
    logic [15:0] base_now;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_BASE_PORT;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_ADD;
    in_ch.client_id   <= '0;
    in_ch.is_chairman <= 1'b0;
    in_ch.audio_port  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, id 0, chairman, full table, port offsets, unused kinds
    write_regs(16'd100, 4'd8);
    send_request(KIND_OLDEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_NEWEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_FREE,   16'd0, 1'b0, 16'd0);
    send_request(KIND_REMOVE, 16'd5, 1'b0, 16'd0);
    send_request(KIND_ADD,    16'd0, 1'b0, 16'd102);
    send_request(KIND_OLDEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_FREE,   16'd0, 1'b0, 16'd0);
    send_request(KIND_ADD,    16'hFFFF, 1'b1, 16'd104);
    send_request(KIND_ADD,    16'd7, 1'b0, 16'd104);
    send_request(KIND_ADD,    16'd9, 1'b0, 16'd116);
    send_request(KIND_ADD,    16'd3, 1'b0, 16'd101);
    send_request(KIND_ADD,    16'd4, 1'b0, 16'd98);
    send_request(KIND_ADD,    16'd5, 1'b0, 16'd118);
    send_request(KIND_ADD,    16'd6, 1'b0, 16'hFFFF);
    send_request(KIND_ADD,    16'd8, 1'b1, 16'd0);
    send_request(KIND_OLDEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_NEWEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_FREE,   16'd0, 1'b0, 16'd0);
    send_request(KIND_REMOVE, 16'd0, 1'b0, 16'd0);
    send_request(KIND_REMOVE, 16'hFFFF, 1'b0, 16'd0);
    send_request(3'd5,        16'hFFFF, 1'b1, 16'hFFFF);
    send_request(3'd7,        16'd0, 1'b0, 16'd0);
    send_request(KIND_REMOVE, 16'd7, 1'b0, 16'd0);
    send_request(KIND_OLDEST, 16'd0, 1'b0, 16'd0);
    send_request(KIND_FREE,   16'd0, 1'b0, 16'd0);

    phase_base[4]  = 16'($urandom);
    phase_limit[4] = 4'($urandom_range(0, 15));
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_regs(phase_base[ph], phase_limit[ph]);
      base_now      = phase_base[ph];
      send_idle_pct = phase_send[ph];
      stall_pct     = phase_stall[ph];
      done = 0;
      while (done < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 35) kind = KIND_ADD;
        else if (roll < 58) kind = KIND_REMOVE;
        else if (roll < 70) kind = KIND_OLDEST;
        else if (roll < 82) kind = KIND_NEWEST;
        else if (roll < 96) kind = KIND_FREE;
        else kind = 3'($urandom_range(5, 7));
        id    = ($urandom_range(99) < 75) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        chair = ($urandom_range(99) < 25);
        roll  = $urandom_range(99);
        if (roll < 60) port = base_now + 16'(2 * $urandom_range(0, 9));
        else if (roll < 80) port = base_now + 16'($urandom_range(0, 20));
        else port = 16'($urandom);
        send_request(kind, id, chair, port);
        if (kind <= KIND_FREE) done++;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sst_pkg.sv
rtl/sst_if.sv
rtl/sst_datapath.sv
rtl/sst_ctrl.sv
rtl/speaker_slot_table.sv
test/slot_table_checker.sv
test/speaker_slot_table_test.sv
